>>> rtl/core/atl_pkg.sv
package atl_pkg;

   // Longest token length that is counted; longer tokens are flagged
   localparam int unsigned MaxTokenLen = 128;

   // Result queue between front and back
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
   localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

   // Scanner states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_IDENT = 3'd1;
   localparam logic [2:0] ST_INT   = 3'd2;
   localparam logic [2:0] ST_DOT   = 3'd3;
   localparam logic [2:0] ST_FRAC  = 3'd4;

   // Byte classes
   localparam logic [2:0] CL_IGNORE = 3'd0;
   localparam logic [2:0] CL_LF     = 3'd1;
   localparam logic [2:0] CL_PUNCT  = 3'd2;
   localparam logic [2:0] CL_DIGIT  = 3'd3;
   localparam logic [2:0] CL_LETTER = 3'd4;

   // Token kinds
   localparam logic [2:0] KIND_PUNCT     = 3'd0;
   localparam logic [2:0] KIND_IDENT     = 3'd1;
   localparam logic [2:0] KIND_NUMBER    = 3'd2;
   localparam logic [2:0] KIND_MALFORMED = 3'd3;
   localparam logic [2:0] KIND_TOO_LONG  = 3'd4;

   localparam logic [7:0]  CHAR_LF   = 8'd10;
   localparam logic [7:0]  CHAR_DOT  = 8'd46;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [2:0]  token_kind;
      logic [6:0]  punct_char;
      logic [7:0]  token_length;
      logic [15:0] token_line;
      logic [15:0] token_column;
      logic        last;
   } rsp_type;

   // Results caused by one byte: one or two
   typedef struct packed {
      logic    has_second;
      rsp_type first;
      rsp_type second;
   } entry_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [2:0] classify(input logic [7:0] c);
      logic [2:0] cl;
      cl = CL_IGNORE;
      if (c == CHAR_LF) begin
         cl = CL_LF;
      end else if (c >= 8'd48 && c <= 8'd57) begin
         cl = CL_DIGIT;
      end else if ((c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122) ||
                   c == 8'd95) begin
         cl = CL_LETTER;
      end else begin
         unique case (c)
            8'd33, 8'd35, 8'd36, 8'd37, 8'd38, 8'd40, 8'd41, 8'd42, 8'd43,
            8'd44, 8'd45, 8'd46, 8'd47, 8'd58, 8'd59, 8'd60, 8'd61, 8'd62,
            8'd64, 8'd91, 8'd93, 8'd96, 8'd124: cl = CL_PUNCT;
            default: cl = CL_IGNORE;
         endcase
      end
      return cl;
   endfunction

endpackage

>>> rtl/core/ascii_token_lexer.sv
// A result is written into the queue when the byte that causes it transfers, and is then
// loaded into the output register once that register is empty or not stalled.
// Throughput: one byte per cycle while the queue is not full; the scanner state is
// registered on each accepted byte. A byte that yields two results uses the result port
// for each; a four-entry queue between scanner and output absorbs that and output stalls.
// Reset (synchronous, active high) returns the scanner to idle at line 1, column 0
// and empties the queue and output register.
module ascii_token_lexer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  atl_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output atl_pkg::rsp_type  rsp_data
);

   logic                       push;
   logic                       pop;
   atl_pkg::entry_type         push_entry;
   atl_pkg::entry_type         pop_entry;
   atl_pkg::queue_status_type  queue_status;

   assign req_stall = queue_status.full;

   atl_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_data     (req_data),
      .queue_status (queue_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   atl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (queue_status)
   );

   atl_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_entry    (pop_entry),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

>>> rtl/core/atl_front.sv
module atl_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  atl_pkg::req_type               req_data,
   input  atl_pkg::queue_status_type      queue_status,
   output logic                           push,
   output atl_pkg::entry_type             push_entry
);

   logic [2:0]  scan_state_ff, scan_state_in;
   logic [7:0]  pending_length_ff, pending_length_in;
   logic        too_long_ff, too_long_in;
   logic [15:0] current_line_ff, current_line_in;
   logic [15:0] current_column_ff, current_column_in;
   logic [15:0] start_line_ff, start_line_in;
   logic [15:0] start_column_ff, start_column_in;

   logic                accept;
   logic [2:0]          cl;
   logic [15:0]         col_next;
   logic                emit;
   logic                fresh;
   logic                punct;
   logic [2:0]          pend_kind;
   atl_pkg::rsp_type    pend_rsp;
   atl_pkg::rsp_type    punct_rsp;

   assign accept = req_valid && !queue_status.full;
   assign cl     = atl_pkg::classify(req_data.char_in);
   assign col_next = (current_column_ff < atl_pkg::COUNT_MAX) ?
                     current_column_ff + 16'd1 : current_column_ff;

   // Kind of the pending token if it ends now
   always_comb begin
      if (too_long_ff) begin
         pend_kind = atl_pkg::KIND_TOO_LONG;
      end else if (scan_state_ff == atl_pkg::ST_IDENT) begin
         pend_kind = atl_pkg::KIND_IDENT;
      end else if (scan_state_ff == atl_pkg::ST_DOT) begin
         pend_kind = atl_pkg::KIND_MALFORMED;
      end else begin
         pend_kind = atl_pkg::KIND_NUMBER;
      end
   end

   always_comb begin
      pend_rsp.token_kind   = pend_kind;
      pend_rsp.punct_char   = 7'd0;
      pend_rsp.token_length = pending_length_ff;
      pend_rsp.token_line   = start_line_ff;
      pend_rsp.token_column = start_column_ff;
      pend_rsp.last         = 1'b0;

      punct_rsp.token_kind   = atl_pkg::KIND_PUNCT;
      punct_rsp.punct_char   = req_data.char_in[6:0];
      punct_rsp.token_length = 8'd1;
      punct_rsp.token_line   = current_line_ff;
      punct_rsp.token_column = col_next;
      punct_rsp.last         = 1'b1;
   end

   // Scan one byte: extend, end or start a token
   always_comb begin
      scan_state_in     = scan_state_ff;
      pending_length_in = pending_length_ff;
      too_long_in       = too_long_ff;
      current_line_in   = current_line_ff;
      current_column_in = current_column_ff;
      start_line_in     = start_line_ff;
      start_column_in   = start_column_ff;
      emit  = 1'b0;
      fresh = 1'b0;
      punct = 1'b0;

      if (req_data.end_of_stream) begin
         if (scan_state_ff != atl_pkg::ST_IDLE) begin
            emit = 1'b1;
         end
      end else begin
         current_column_in = col_next;
         fresh = 1'b1;
         unique case (scan_state_ff)
            atl_pkg::ST_IDENT: begin
               if (cl == atl_pkg::CL_LETTER || cl == atl_pkg::CL_DIGIT) begin
                  fresh = 1'b0;
               end else begin
                  emit = 1'b1;
               end
            end
            atl_pkg::ST_INT: begin
               if (cl == atl_pkg::CL_DIGIT) begin
                  fresh = 1'b0;
               end else if (req_data.char_in == atl_pkg::CHAR_DOT) begin
                  fresh = 1'b0;
                  scan_state_in = atl_pkg::ST_DOT;
               end else begin
                  emit = 1'b1;
               end
            end
            atl_pkg::ST_DOT: begin
               if (cl == atl_pkg::CL_DIGIT) begin
                  fresh = 1'b0;
                  scan_state_in = atl_pkg::ST_FRAC;
               end else begin
                  emit = 1'b1;
               end
            end
            atl_pkg::ST_FRAC: begin
               if (cl == atl_pkg::CL_DIGIT) begin
                  fresh = 1'b0;
               end else begin
                  emit = 1'b1;
               end
            end
            default: begin
            end
         endcase

         // Append the byte to the pending token
         if (!fresh) begin
            if (pending_length_ff < 8'(atl_pkg::MaxTokenLen)) begin
               pending_length_in = pending_length_ff + 8'd1;
            end else begin
               too_long_in = 1'b1;
            end
         end
      end

      if (emit) begin
         scan_state_in     = atl_pkg::ST_IDLE;
         pending_length_in = 8'd0;
         too_long_in       = 1'b0;
      end

      // Handle the byte as if nothing were pending
      if (fresh) begin
         unique case (cl)
            atl_pkg::CL_LF: begin
               if (current_line_ff < atl_pkg::COUNT_MAX) begin
                  current_line_in = current_line_ff + 16'd1;
               end
               current_column_in = 16'd0;
            end
            atl_pkg::CL_PUNCT: begin
               punct = 1'b1;
            end
            atl_pkg::CL_LETTER, atl_pkg::CL_DIGIT: begin
               scan_state_in     = (cl == atl_pkg::CL_LETTER) ?
                                   atl_pkg::ST_IDENT : atl_pkg::ST_INT;
               pending_length_in = 8'd1;
               too_long_in       = 1'b0;
               start_line_in     = current_line_ff;
               start_column_in   = col_next;
            end
            default: begin
            end
         endcase
      end
   end

   // Pack the results of this byte for the queue
   always_comb begin
      push_entry.has_second = emit && punct;
      push_entry.first      = emit ? pend_rsp : punct_rsp;
      push_entry.first.last = !(emit && punct);
      push_entry.second     = punct_rsp;
      push = accept && (emit || punct);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_state_ff     <= atl_pkg::ST_IDLE;
         pending_length_ff <= 8'd0;
         too_long_ff       <= 1'b0;
         current_line_ff   <= 16'd1;
         current_column_ff <= 16'd0;
         start_line_ff     <= 16'd1;
         start_column_ff   <= 16'd0;
      end else if (accept) begin
         scan_state_ff     <= scan_state_in;
         pending_length_ff <= pending_length_in;
         too_long_ff       <= too_long_in;
         current_line_ff   <= current_line_in;
         current_column_ff <= current_column_in;
         start_line_ff     <= start_line_in;
         start_column_ff   <= start_column_in;
      end
   end

endmodule

>>> rtl/core/atl_queue.sv
module atl_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  atl_pkg::entry_type         push_entry,
   input  logic                       pop,
   output atl_pkg::entry_type         pop_entry,
   output atl_pkg::queue_status_type  status
);

   atl_pkg::entry_type                  store_ff [atl_pkg::QueueDepth];
   logic [atl_pkg::QueuePtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [atl_pkg::QueuePtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [atl_pkg::QueueCntW-1:0]       count_ff, count_in;

   assign status.full  = (count_ff == atl_pkg::QueueCntW'(atl_pkg::QueueDepth));
   assign status.empty = (count_ff == '0);
   assign pop_entry    = store_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == atl_pkg::QueuePtrW'(atl_pkg::QueueDepth - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == atl_pkg::QueuePtrW'(atl_pkg::QueueDepth - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold entries
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/core/atl_back.sv
module atl_back (
   input  logic                       clock,
   input  logic                       reset,
   input  atl_pkg::entry_type         pop_entry,
   input  atl_pkg::queue_status_type  queue_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output atl_pkg::rsp_type           rsp_data
);

   logic              out_valid_ff;
   atl_pkg::rsp_type  out_ff;
   logic              spare_valid_ff;
   atl_pkg::rsp_type  spare_ff;
   logic              load;

   assign load      = !out_valid_ff || !rsp_stall;
   assign pop       = load && !spare_valid_ff && !queue_status.empty;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Control: drain the spare slot before taking a new entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else if (load) begin
         if (spare_valid_ff) begin
            out_valid_ff   <= 1'b1;
            spare_valid_ff <= 1'b0;
         end else if (!queue_status.empty) begin
            out_valid_ff   <= 1'b1;
            spare_valid_ff <= pop_entry.has_second;
         end else begin
            out_valid_ff   <= 1'b0;
         end
      end
   end

   // Payload: load the output register and the spare result
   always_ff @(posedge clock) begin
      if (load) begin
         if (spare_valid_ff) begin
            out_ff <= spare_ff;
         end else if (!queue_status.empty) begin
            out_ff   <= pop_entry.first;
            spare_ff <= pop_entry.second;
         end
      end
   end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;

   // Punctuation bytes, one per token; backquote is spelled as a code
   localparam logic [23*8-1:0] PunctList = {"!#$%&()*+,-./:;<=>@[]", 8'd96, "|"};
   localparam int unsigned PunctCount = 23;
   localparam int unsigned WatchdogLimit = 1000;
   localparam int unsigned MaxShown = 10;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   atl_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   atl_pkg::rsp_type rsp_data;

   // Lexer state as predicted from accepted bytes
   logic [2:0]  scan_q = atl_pkg::ST_IDLE;
   logic [7:0]  tok_len = '0;
   logic        tok_overflow = 1'b0;
   logic [15:0] line_now = 16'd1;
   logic [15:0] col_now = '0;
   logic [15:0] tok_line = 16'd1;
   logic [15:0] tok_col = '0;

   atl_pkg::req_type pending_bytes[$];
   atl_pkg::rsp_type expected_tokens[$];
   int          fail_count = 0;
   int          send_gap = 0;
   int          hold_gap = 0;
   int unsigned idle_cycles = 0;
   logic [31:0] cycle_count = '0;
   logic        calm = 1'b0;
   logic        quiet;

   ascii_token_lexer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Alternate stretches with and without idling; none at the end
   assign quiet = calm || cycle_count[8];

   function automatic logic [2:0] byte_class(input logic [7:0] b);
      logic [2:0] cls;
      cls = atl_pkg::CL_IGNORE;
      if (b == atl_pkg::CHAR_LF) begin
         cls = atl_pkg::CL_LF;
      end else if (b >= "0" && b <= "9") begin
         cls = atl_pkg::CL_DIGIT;
      end else if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_") begin
         cls = atl_pkg::CL_LETTER;
      end else begin
         for (int k = 0; k < PunctCount; k++) begin
            if (b == PunctList[8*k +: 8]) cls = atl_pkg::CL_PUNCT;
         end
      end
      return cls;
   endfunction

   // Report the pending token and return to idle
   function automatic atl_pkg::rsp_type close_token();
      atl_pkg::rsp_type t;
      t = '0;
      if (tok_overflow) t.token_kind = atl_pkg::KIND_TOO_LONG;
      else if (scan_q == atl_pkg::ST_IDENT) t.token_kind = atl_pkg::KIND_IDENT;
      else if (scan_q == atl_pkg::ST_DOT) t.token_kind = atl_pkg::KIND_MALFORMED;
      else t.token_kind = atl_pkg::KIND_NUMBER;
      t.token_length = tok_len;
      t.token_line = tok_line;
      t.token_column = tok_col;
      scan_q = atl_pkg::ST_IDLE;
      tok_len = '0;
      tok_overflow = 1'b0;
      return t;
   endfunction

   task automatic grow_token();
      if (tok_len < atl_pkg::MaxTokenLen) tok_len++;
      else tok_overflow = 1'b1;
   endtask

   task automatic open_token(input logic [2:0] st);
      scan_q = st;
      tok_len = 8'd1;
      tok_overflow = 1'b0;
      tok_line = line_now;
      tok_col = col_now;
   endtask

   // Advance the predicted lexer by one byte and queue the tokens it yields
   task automatic lex_byte(input atl_pkg::req_type item);
      atl_pkg::rsp_type toks[$];
      atl_pkg::rsp_type tok;
      logic [2:0]       cls;
      logic             absorbed;
      if (scan_q > atl_pkg::ST_FRAC) scan_q = atl_pkg::ST_IDLE;
      if (item.end_of_stream) begin
         if (scan_q != atl_pkg::ST_IDLE) toks.push_back(close_token());
      end else begin
         if (col_now != atl_pkg::COUNT_MAX) col_now++;
         cls = byte_class(item.char_in);
         absorbed = 1'b0;
         case (scan_q)
            atl_pkg::ST_IDENT: begin
               if (cls == atl_pkg::CL_LETTER || cls == atl_pkg::CL_DIGIT) begin
                  grow_token();
                  absorbed = 1'b1;
               end
            end
            atl_pkg::ST_INT: begin
               if (cls == atl_pkg::CL_DIGIT) begin
                  grow_token();
                  absorbed = 1'b1;
               end else if (item.char_in == atl_pkg::CHAR_DOT) begin
                  grow_token();
                  scan_q = atl_pkg::ST_DOT;
                  absorbed = 1'b1;
               end
            end
            atl_pkg::ST_DOT: begin
               if (cls == atl_pkg::CL_DIGIT) begin
                  grow_token();
                  scan_q = atl_pkg::ST_FRAC;
                  absorbed = 1'b1;
               end
            end
            atl_pkg::ST_FRAC: begin
               if (cls == atl_pkg::CL_DIGIT) begin
                  grow_token();
                  absorbed = 1'b1;
               end
            end
            default: ;
         endcase
         // A byte that ends a token is handled again from idle
         if (!absorbed && scan_q != atl_pkg::ST_IDLE) toks.push_back(close_token());
         if (!absorbed) begin
            case (cls)
               atl_pkg::CL_LF: begin
                  if (line_now != atl_pkg::COUNT_MAX) line_now++;
                  col_now = '0;
               end
               atl_pkg::CL_PUNCT: begin
                  tok = '0;
                  tok.token_kind = atl_pkg::KIND_PUNCT;
                  tok.punct_char = item.char_in[6:0];
                  tok.token_length = 8'd1;
                  tok.token_line = line_now;
                  tok.token_column = col_now;
                  toks.push_back(tok);
               end
               atl_pkg::CL_LETTER: open_token(atl_pkg::ST_IDENT);
               atl_pkg::CL_DIGIT:  open_token(atl_pkg::ST_INT);
               default: ;
            endcase
         end
      end
      if (toks.size() > 0) toks[toks.size() - 1].last = 1'b1;
      foreach (toks[k]) expected_tokens.push_back(toks[k]);
   endtask

   task automatic push_char(input logic [7:0] c);
      pending_bytes.push_back('{char_in: c, end_of_stream: 1'b0});
   endtask

   task automatic push_eos();
      pending_bytes.push_back('{char_in: 8'($urandom_range(0, 255)), end_of_stream: 1'b1});
   endtask

   task automatic push_text(input string s);
      for (int k = 0; k < s.len(); k++) push_char(s[k]);
   endtask

   function automatic logic [7:0] letter_char();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return "A" + 8'(r);
      if (r < 52) return "a" + 8'(r - 26);
      return "_";
   endfunction

   function automatic logic [7:0] digit_char();
      return "0" + 8'($urandom_range(0, 9));
   endfunction

   // Mostly well-formed tokens with random content, some noise and stray ends
   task automatic push_random_text(input int target);
      int stop;
      int len;
      int pick;
      stop = pending_bytes.size() + target;
      while (pending_bytes.size() < stop) begin
         pick = $urandom_range(0, 99);
         len = ($urandom_range(0, 19) == 0) ?
               $urandom_range(atl_pkg::MaxTokenLen - 3, atl_pkg::MaxTokenLen + 4)
               : $urandom_range(1, 6);
         if (pick < 25) begin
            push_char(letter_char());
            repeat (len - 1) push_char(($urandom_range(0, 3) == 0) ? digit_char() : letter_char());
         end else if (pick < 45) begin
            repeat (len) push_char(digit_char());
            pick = $urandom_range(0, 2);
            if (pick == 1) begin
               push_char(atl_pkg::CHAR_DOT);
               repeat (($urandom_range(0, 9) == 0) ? atl_pkg::MaxTokenLen : $urandom_range(1, 4))
                  push_char(digit_char());
            end else if (pick == 2) begin
               // dot with whatever follows: malformed unless a digit comes next
               push_char(atl_pkg::CHAR_DOT);
            end
         end else if (pick < 65) begin
            push_char(PunctList[8*$urandom_range(0, PunctCount - 1) +: 8]);
         end else if (pick < 77) begin
            pick = $urandom_range(0, 2);
            push_char((pick == 0) ? atl_pkg::CHAR_LF : (pick == 1) ? " " : 8'd9);
         end else if (pick < 90) begin
            push_char(8'($urandom_range(0, 255)));
         end else begin
            push_eos();
         end
      end
   endtask

   // Hold until the sender is empty and every expected token has arrived
   task automatic drain();
      while (pending_bytes.size() > 0 || req_valid || expected_tokens.size() > 0)
         @(posedge clock);
   endtask

   // Driver: present queued bytes, with random idle bursts
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) lex_byte(req_data);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 2);
               req_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               req_data <= pending_bytes.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each token transfer against the oldest expectation
   always @(posedge clock) begin
      atl_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_gap = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_tokens.size() == 0) begin
               fail_count++;
               if (fail_count <= MaxShown)
                  $display("unexpected token: kind %0d len %0d line %0d col %0d",
                           rsp_data.token_kind, rsp_data.token_length,
                           rsp_data.token_line, rsp_data.token_column);
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_data.token_kind !== want.token_kind ||
                   rsp_data.punct_char !== want.punct_char ||
                   rsp_data.token_length !== want.token_length ||
                   rsp_data.token_line !== want.token_line ||
                   rsp_data.token_column !== want.token_column ||
                   rsp_data.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= MaxShown)
                     $display({"token mismatch (expected/actual): kind %0d/%0d char %0d/%0d ",
                               "len %0d/%0d line %0d/%0d col %0d/%0d last %0b/%0b"},
                              want.token_kind, rsp_data.token_kind,
                              want.punct_char, rsp_data.punct_char,
                              want.token_length, rsp_data.token_length,
                              want.token_line, rsp_data.token_line,
                              want.token_column, rsp_data.token_column,
                              want.last, rsp_data.last);
               end
            end
         end
         if (hold_gap > 0) begin
            hold_gap--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            hold_gap = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: end the run if no transfer happens for too long
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("FAIL ascii_token_lexer");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      // Directed: flush by end of stream, two tokens from one byte, fraction,
      // malformed number ended by a letter and by end of stream, dot after dot
      push_text("a");
      push_eos();
      push_text("_z9+12.5;7.x\n3.");
      push_eos();
      push_text("0..");
      push_char(8'd0);
      push_char(8'd255);
      push_char(8'd127);
      push_char("\"");
      push_eos();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      push_random_text(900);
      drain();
      push_random_text(600);
      while (pending_bytes.size() > 0) @(posedge clock);

      // Last part: no idling
      calm = 1'b1;
      push_random_text(250);
      push_text("x1 5.5,");
      push_eos();

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS ascii_token_lexer");
      end else begin
         $display("FAIL ascii_token_lexer");
      end
      $finish;
   end

endmodule
